### hdl/attp_pkg.sv
// Shared types, codes and grammar helpers for the attribute text parser.
package attp_pkg;

    localparam int MAX_TEXT_DEF = 4096;
    localparam int POS_MAXW     = 17;
    localparam int SAT_MAX      = 4095;
    localparam int QDEPTH       = 4;
    localparam int QAW          = 2;

    // lexer modes
    localparam logic [2:0] LM_IDLE = 3'd0;
    localparam logic [2:0] LM_SYM  = 3'd1;
    localparam logic [2:0] LM_NUM  = 3'd2;
    localparam logic [2:0] LM_STR  = 3'd3;
    localparam logic [2:0] LM_DONE = 3'd4;

    // grammar states
    localparam logic [2:0] GS_FIRST      = 3'd0;
    localparam logic [2:0] GS_NAME       = 3'd1;
    localparam logic [2:0] GS_AFTER_NAME = 3'd2;
    localparam logic [2:0] GS_VALUE      = 3'd3;
    localparam logic [2:0] GS_AFTER_VAL  = 3'd4;
    localparam logic [2:0] GS_STOP       = 3'd5;

    // token kinds
    localparam logic [2:0] TK_EQ    = 3'd0;
    localparam logic [2:0] TK_COMMA = 3'd1;
    localparam logic [2:0] TK_INT   = 3'd2;
    localparam logic [2:0] TK_FLOAT = 3'd3;
    localparam logic [2:0] TK_SYM   = 3'd4;
    localparam logic [2:0] TK_STR   = 3'd5;

    // record status codes; end status shares the error codes
    localparam logic [1:0] REC_ATTR  = 2'd0;
    localparam logic [1:0] REC_OK    = 2'd1;
    localparam logic [1:0] REC_LEX   = 2'd2;
    localparam logic [1:0] REC_PARSE = 2'd3;
    localparam logic [1:0] ES_OK     = 2'd0;

    // value kinds
    localparam logic [2:0] VK_FLAG  = 3'd0;
    localparam logic [2:0] VK_INT   = 3'd1;
    localparam logic [2:0] VK_FLOAT = 3'd2;
    localparam logic [2:0] VK_SYM   = 3'd3;
    localparam logic [2:0] VK_STR   = 3'd4;

    // characters
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] name_start;
        logic [11:0] name_length;
        logic [2:0]  value_kind;
        logic [11:0] value_start;
        logic [11:0] value_length;
        logic        final_res;
    } t_out;

    typedef struct packed {
        logic [2:0]  gs;
        logic [11:0] hs;
        logic [11:0] hl;
        logic [1:0]  es;
    } t_gram;

    typedef struct packed {
        t_gram g;
        logic  emit;
        t_out  rec;
    } t_feed;

    // records produced by one transfer, in order
    typedef struct packed {
        logic [1:0] n;
        t_out       r0;
        t_out       r1;
    } t_slots;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic t_gram parse_err(t_gram g_in);
        t_gram g;
        g = g_in;
        if (g.es == ES_OK) begin
            g.es = REC_PARSE;
        end
        g.gs = GS_STOP;
        return g;
    endfunction

    function automatic t_out flag_rec(t_gram g);
        t_out r;
        r = '0;
        r.status      = REC_ATTR;
        r.name_start  = g.hs;
        r.name_length = g.hl;
        r.value_kind  = VK_FLAG;
        return r;
    endfunction

    function automatic t_out status_rec(logic [1:0] es);
        t_out r;
        r = '0;
        r.status    = (es == ES_OK) ? REC_OK : es;
        r.final_res = 1'b1;
        return r;
    endfunction

    function automatic t_slots push(t_slots s_in, logic v, t_out r);
        t_slots s;
        s = s_in;
        if (v) begin
            if (s.n == 2'd0) begin
                s.r0 = r;
                s.n  = 2'd1;
            end else if (s.n == 2'd1) begin
                s.r1 = r;
                s.n  = 2'd2;
            end
        end
        return s;
    endfunction

    function automatic t_feed feed(t_gram g, logic [2:0] kind, logic [11:0] start,
                                   logic [11:0] len);
        t_feed f;
        f.g    = g;
        f.emit = 1'b0;
        f.rec  = '0;
        unique case (g.gs)
            GS_FIRST, GS_NAME: begin
                if (kind == TK_SYM) begin
                    f.g.hs = start;
                    f.g.hl = len;
                    f.g.gs = GS_AFTER_NAME;
                end else begin
                    f.g = parse_err(g);
                end
            end
            GS_AFTER_NAME: begin
                if (kind == TK_EQ) begin
                    f.g.gs = GS_VALUE;
                end else begin
                    f.emit = 1'b1;
                    f.rec  = flag_rec(g);
                    f.g.gs = (kind == TK_COMMA) ? GS_NAME : GS_STOP;
                end
            end
            GS_VALUE: begin
                if (kind == TK_EQ || kind == TK_COMMA) begin
                    f.g = parse_err(g);
                end else begin
                    f.emit             = 1'b1;
                    f.rec.status       = REC_ATTR;
                    f.rec.name_start   = g.hs;
                    f.rec.name_length  = g.hl;
                    f.rec.value_kind   = (kind == TK_INT)   ? VK_INT :
                                         (kind == TK_FLOAT) ? VK_FLOAT :
                                         (kind == TK_SYM)   ? VK_SYM : VK_STR;
                    f.rec.value_start  = start;
                    f.rec.value_length = len;
                    f.g.gs             = GS_AFTER_VAL;
                end
            end
            GS_AFTER_VAL: begin
                f.g.gs = (kind == TK_COMMA) ? GS_NAME : GS_STOP;
            end
            default: begin
            end
        endcase
        return f;
    endfunction

endpackage

### hdl/attp_rec_fifo.sv
// Record queue between the parser and the result channel.
module attp_rec_fifo
    import attp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_slots i_push,
    input  logic   i_pop,
    output logic   o_room,
    output logic   o_valid,
    output t_out   o_rec
);

    t_out             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr;
    logic [QAW:0]     r_count;
    logic [QAW-1:0]   n_wr_ptr;
    logic [QAW-1:0]   n_rd_ptr;
    logic [QAW:0]     n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QAW'(i_push.n);
        n_rd_ptr = r_rd_ptr + QAW'(i_pop);
        n_count  = r_count + (QAW+1)'(i_push.n) - (QAW+1)'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[QAW'(r_wr_ptr + QAW'(1))] <= i_push.r1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= (QAW+1)'(QDEPTH - 2));
    assign o_rec   = r_mem[r_rd_ptr];

endmodule

### hdl/attribute_text_tokenizer_parser.sv
// Attribute text tokenizer and parser: one text byte per transfer in, records out.
//
// Input channel: one byte of attribute text per transfer, with last set on the
// final byte. A zero byte ends the text early; bytes after it up to last are
// ignored. Output channel: one record per transfer, either an attribute record
// (name span, value kind, value span) or, once per text, the status record
// with final_res set (ok, lex error: drop every record of this text, parse
// error: earlier records stand).
// Throughput: one byte per cycle while the queue has room. Each byte is
// classified and the lexer and grammar state updated in the same cycle; the
// records it yields go into a four-entry queue, and the output drains one
// record per cycle while the receiver does not stall. A byte yields at most
// two records, so the input stalls only while the queue holds more than two
// records. Records are offered in the order in which they were produced.
// Reset empties the queue and returns the parser to the start of a text; the
// parser also returns there after every last byte. While the receiver stalls,
// the offered record holds and input flows until over two records are queued.
module attribute_text_tokenizer_parser
    import attp_pkg::*;
#(
    parameter int MAX_TEXT = MAX_TEXT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int PW = $clog2(MAX_TEXT + 1);

    typedef struct packed {
        logic [2:0]    lm;
        logic          dot;
        logic [PW-1:0] ts;
        logic [PW-1:0] bp;
        t_gram         g;
    } t_state;

    typedef struct packed {
        t_state st;
        t_slots sl;
    } t_work;

    t_state r_st;
    t_state n_st;
    t_work  w_work;
    t_slots w_push;
    logic   w_acc;
    logic   w_room;
    logic   w_pop;

    function automatic t_state reset_state();
        t_state s;
        s      = '0;
        s.lm   = LM_IDLE;
        s.g.gs = GS_FIRST;
        s.g.es = ES_OK;
        return s;
    endfunction

    function automatic logic [11:0] sat12(logic [PW-1:0] v);
        logic [POS_MAXW-1:0] x;
        x = POS_MAXW'(v);
        return (x > POS_MAXW'(SAT_MAX)) ? 12'(SAT_MAX) : x[11:0];
    endfunction

    function automatic t_work lex_err(t_work w_in);
        t_work w;
        w         = w_in;
        w.st.g.es = REC_LEX;
        w.st.lm   = LM_DONE;
        w.st.g.gs = GS_STOP;
        return w;
    endfunction

    function automatic t_work feed_push(t_work w_in, logic [2:0] kind, logic [11:0] start,
                                        logic [11:0] len);
        t_work w;
        t_feed f;
        w      = w_in;
        f      = feed(w.st.g, kind, start, len);
        w.st.g = f.g;
        w.sl   = push(w.sl, f.emit, f.rec);
        return w;
    endfunction

    function automatic t_work finish_token(t_work w_in);
        t_work       w;
        logic [11:0] len;
        w   = w_in;
        len = sat12(w.st.bp - w.st.ts);
        if (w.st.lm == LM_SYM) begin
            w = feed_push(w, TK_SYM, sat12(w.st.ts), len);
        end else if (w.st.lm == LM_NUM) begin
            w = feed_push(w, w.st.dot ? TK_FLOAT : TK_INT, sat12(w.st.ts), len);
        end
        w.st.lm = LM_IDLE;
        return w;
    endfunction

    function automatic t_work end_text(t_work w_in);
        t_work w;
        w = w_in;
        if (w.st.lm == LM_STR) begin
            w = lex_err(w);
        end else if (w.st.lm != LM_DONE) begin
            w = finish_token(w);
            if (w.st.g.gs == GS_AFTER_NAME) begin
                w.sl = push(w.sl, 1'b1, flag_rec(w.st.g));
            end else if (w.st.g.gs == GS_NAME || w.st.g.gs == GS_VALUE) begin
                w.st.g = parse_err(w.st.g);
            end
            w.st.g.gs = GS_STOP;
            w.st.lm   = LM_DONE;
        end
        return w;
    endfunction

    function automatic t_work lex_byte(t_work w_in, logic [7:0] c);
        t_work w;
        logic  taken;
        logic  ok;
        w     = w_in;
        taken = 1'b0;
        ok    = 1'b1;
        if (w.st.bp >= PW'(MAX_TEXT)) begin
            w = lex_err(w);
        end else if (w.st.lm == LM_STR) begin
            if (c == CH_QUOTE) begin
                w = feed_push(w, TK_STR, sat12(w.st.ts), sat12(w.st.bp - w.st.ts));
                w.st.lm = LM_IDLE;
            end
            w.st.bp = w.st.bp + PW'(1);
        end else begin
            if (w.st.lm == LM_SYM && (is_alpha(c) || is_digit(c) || c == CH_USCORE)) begin
                taken   = 1'b1;
                w.st.bp = w.st.bp + PW'(1);
            end else if (w.st.lm == LM_NUM && is_digit(c)) begin
                taken   = 1'b1;
                w.st.bp = w.st.bp + PW'(1);
            end else if (w.st.lm == LM_NUM && c == CH_DOT) begin
                taken = 1'b1;
                if (w.st.dot) begin
                    w = lex_err(w);
                end else begin
                    w.st.dot = 1'b1;
                    w.st.bp  = w.st.bp + PW'(1);
                end
            end
            if (!taken) begin
                if (w.st.lm == LM_SYM || w.st.lm == LM_NUM) begin
                    w = finish_token(w);
                end
                if (c == CH_EQ) begin
                    w = feed_push(w, TK_EQ, sat12(w.st.bp), 12'd1);
                end else if (c == CH_COMMA) begin
                    w = feed_push(w, TK_COMMA, sat12(w.st.bp), 12'd1);
                end else if (c == CH_QUOTE) begin
                    w.st.lm = LM_STR;
                    w.st.ts = w.st.bp + PW'(1);
                end else if (c == CH_SPACE || c == CH_TAB) begin
                    ok = 1'b1;
                end else if (c == CH_USCORE || is_alpha(c)) begin
                    w.st.lm = LM_SYM;
                    w.st.ts = w.st.bp;
                end else if (is_digit(c)) begin
                    w.st.lm  = LM_NUM;
                    w.st.dot = 1'b0;
                    w.st.ts  = w.st.bp;
                end else begin
                    ok = 1'b0;
                    w  = lex_err(w);
                end
                if (ok) begin
                    w.st.bp = w.st.bp + PW'(1);
                end
            end
        end
        return w;
    endfunction

    always_comb begin
        w_work    = '0;
        w_work.st = r_st;
        if (w_work.st.lm != LM_DONE) begin
            if (i_in_data.text_byte == CH_NUL) begin
                w_work = end_text(w_work);
            end else begin
                w_work = lex_byte(w_work, i_in_data.text_byte);
            end
        end
        if (i_in_data.last) begin
            w_work    = end_text(w_work);
            w_work.sl = push(w_work.sl, 1'b1, status_rec(w_work.st.g.es));
            w_work.st = reset_state();
        end
    end

    assign w_acc      = i_in_valid && w_room;
    assign o_in_stall = !w_room;
    assign w_pop      = o_out_valid && !i_out_stall;

    always_comb begin
        n_st   = w_acc ? w_work.st : r_st;
        w_push = w_acc ? w_work.sl : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= reset_state();
        end else begin
            r_st <= n_st;
        end
    end

    attp_rec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .o_rec   (o_out_data)
    );

endmodule

### hdl/attp_checker.sv
// Port-level checks for the attribute text parser, bound to the top level.
module attp_checker
    import attp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_in  i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_final_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.final_res == (o_out_data.status != REC_ATTR)))
        else $error("final_res disagrees with status");

    a_flag_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.final_res && o_out_data.value_kind == VK_FLAG
        |-> o_out_data.value_start == 12'd0 && o_out_data.value_length == 12'd0)
        else $error("flag record carries a value span");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.last |=> o_out_valid)
        else $error("no record queued after last byte");

endmodule

bind attribute_text_tokenizer_parser attp_checker u_attp_checker (.*);
